FILE: hw/rtl/sine_wave_position_generator_assert.svh
// Assertion macros for the sine wave position generator.
// Used by the top level only; needs nothing else.
`ifndef SINE_WAVE_POSITION_GENERATOR_ASSERT_SVH
`define SINE_WAVE_POSITION_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SWPG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swpg: same-cycle check failed");

// next-cycle implication
`define SWPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swpg: next-cycle check failed");

`endif

FILE: hw/rtl/swpg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the position generator.
// No dependencies.
package swpg_pkg;

   localparam int SINE_TABLE_DEPTH    = 256;
   localparam int PHASE_FRACTION_BITS = 16;
   localparam int TAB_BITS            = $clog2(SINE_TABLE_DEPTH);
   localparam int POS_W               = TAB_BITS + 2;
   localparam int PHASE_W             = 32;
   localparam int ALU_W               = 36;
   localparam int MAG_W               = 15;
   localparam int SINE_W              = MAG_W + 2;
   localparam int PROD_W              = PHASE_W + SINE_W;
   localparam int CNT_W               = $clog2(PHASE_W + PHASE_FRACTION_BITS + 1);
   localparam logic [63:0] PI_Q62     = 64'hC90F_DAA2_2168_C235;
   localparam logic [MAG_W-1:0] MAG_PEAK = {MAG_W{1'b1}};

   typedef enum logic [1:0] {
      CSR_MIN_LENGTH  = 2'd0,
      CSR_MAX_LENGTH  = 2'd1,
      CSR_WAVE_PERIOD = 2'd2
   } swpg_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_ACCUM,
      ST_WRAP,
      ST_CHECK,
      ST_DIVIDE,
      ST_AMP,
      ST_MULT,
      ST_SUM1,
      ST_SUM2,
      ST_DONE
   } swpg_state_type;

   typedef struct packed {
      logic [PHASE_W-1:0] min_length;
      logic [PHASE_W-1:0] max_length;
      logic [PHASE_W-1:0] wave_period;
   } swpg_cfg_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } swpg_alu_op_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             neg;
   } swpg_alu_res_type;

   typedef logic [MAG_W-1:0] swpg_tab_type [SINE_TABLE_DEPTH];

   // quarter-wave table, Taylor series in Q62 then rounded to unsigned Q0.15
   function automatic swpg_tab_type build_sine_tab();
      swpg_tab_type tab;
      logic [127:0] pr;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sm;
      logic [63:0]  v;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         pr = 128'(PI_Q62) * 128'(64'(i) << (63 - TAB_BITS));
         x  = pr[127:64];
         pr = 128'(x) * 128'(x);
         x2 = pr[125:62];
         term = x;
         sm   = x;
         for (int k = 1; k <= 13; k++) begin
            pr   = 128'(term) * 128'(x2);
            term = pr[125:62] / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               sm = sm - term;
            end else begin
               sm = sm + term;
            end
         end
         v = (sm + (64'd1 << 46)) >> 47;
         tab[i] = (v > 64'(MAG_PEAK)) ? MAG_PEAK : v[MAG_W-1:0];
      end
      return tab;
   endfunction

   localparam swpg_tab_type SINE_TAB = build_sine_tab();

endpackage

FILE: hw/rtl/swpg_alu.sv
// Shared add/subtract unit of the position generator.
// Depends on swpg_pkg.
module swpg_alu (
   input  swpg_pkg::swpg_alu_op_type  op,
   output swpg_pkg::swpg_alu_res_type res
);

   logic [swpg_pkg::ALU_W-1:0] b_eff;
   logic [swpg_pkg::ALU_W-1:0] sum;

   assign b_eff   = op.sub ? ~op.b : op.b;
   assign sum     = op.a + b_eff + swpg_pkg::ALU_W'(op.sub);
   assign res.sum = sum;
   assign res.neg = sum[swpg_pkg::ALU_W-1];

endmodule

FILE: hw/rtl/swpg_sine.sv
// Quadrant fold and quarter-wave table lookup, registered sine sample.
// Depends on swpg_pkg.
module swpg_sine (
   input  logic                                         clock,
   input  logic [swpg_pkg::PHASE_FRACTION_BITS-1:0]     fraction,
   output logic signed [swpg_pkg::SINE_W-1:0]           sine
);

   localparam int F  = swpg_pkg::PHASE_FRACTION_BITS;
   localparam int TB = swpg_pkg::TAB_BITS;

   logic [F+TB+1:0]                 ext;
   logic [swpg_pkg::POS_W-1:0]      pos;
   logic [TB-1:0]                   idx;
   logic [TB-1:0]                   idx_mirror;
   logic [1:0]                      quad;
   logic [swpg_pkg::MAG_W-1:0]      mag;
   logic signed [swpg_pkg::SINE_W-1:0] sine_in;
   logic signed [swpg_pkg::SINE_W-1:0] sine_ff;

   assign ext        = {fraction, (TB + 2)'(0)};
   assign pos        = ext[F+TB+1:F];
   assign idx        = pos[TB-1:0];
   assign quad       = pos[TB+1:TB];
   assign idx_mirror = TB'(0) - idx;

   always_comb begin
      if (quad[0]) begin
         mag = (idx == TB'(0)) ? swpg_pkg::MAG_PEAK : swpg_pkg::SINE_TAB[idx_mirror];
      end else begin
         mag = swpg_pkg::SINE_TAB[idx];
      end
      if (quad[1]) begin
         sine_in = -$signed({2'b00, mag});
      end else begin
         sine_in = $signed({2'b00, mag});
      end
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

FILE: hw/rtl/swpg_core.sv
// Sequencer and datapath registers of the position generator: phase update,
// restoring division, scaling and output register. Depends on swpg_pkg, swpg_alu, swpg_sine.
module swpg_core (
   input  logic                           clock,
   input  logic                           reset,
   input  swpg_pkg::swpg_cfg_type         cfg,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [31:0]                    req_delta_t,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_position,
   output logic                           rsp_wrapped
);

   localparam int F  = swpg_pkg::PHASE_FRACTION_BITS;
   localparam int W  = swpg_pkg::PHASE_W;
   localparam int AW = swpg_pkg::ALU_W;
   localparam int CW = swpg_pkg::CNT_W;

   swpg_pkg::swpg_state_type state_ff, state_in;
   swpg_pkg::swpg_alu_op_type  alu_op;
   swpg_pkg::swpg_alu_res_type alu_res;

   logic [W-1:0]       period;
   logic [W-1:0]       delta_ff, delta_in;
   logic [W-1:0]       phase_ff, phase_in;
   logic [W:0]         sum_ff, sum_in;
   logic               wrapped_ff, wrapped_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [W-1:0]       dvd_ff, dvd_in;
   logic [F-1:0]       quo_ff, quo_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [W-1:0] amp_ff, amp_in;
   logic signed [swpg_pkg::SINE_W-1:0] sine;
   logic signed [swpg_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]       rsp_position_ff, rsp_position_in;
   logic               rsp_wrapped_ff, rsp_wrapped_in;
   logic               slot_free;
   logic               acc_fits;
   logic [W-1:0]       acc_sat;

   swpg_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   swpg_sine u_sine (
      .clock    (clock),
      .fraction (quo_ff),
      .sine     (sine)
   );

   assign period    = (cfg.wave_period == '0) ? W'(1) : cfg.wave_period;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign acc_fits  = (&acc_ff[AW-1:W-1]) || !(|acc_ff[AW-1:W-1]);
   assign acc_sat   = acc_fits ? acc_ff[W-1:0] :
                      (acc_ff[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swpg_pkg::ST_IDLE:   if (req_valid) state_in = swpg_pkg::ST_CLAMP;
         swpg_pkg::ST_CLAMP:  state_in = swpg_pkg::ST_ACCUM;
         swpg_pkg::ST_ACCUM:  state_in = swpg_pkg::ST_WRAP;
         swpg_pkg::ST_WRAP:   state_in = swpg_pkg::ST_CHECK;
         swpg_pkg::ST_CHECK:  state_in = swpg_pkg::ST_DIVIDE;
         swpg_pkg::ST_DIVIDE: if (cnt_ff == CW'(1)) state_in = swpg_pkg::ST_AMP;
         swpg_pkg::ST_AMP:    state_in = swpg_pkg::ST_MULT;
         swpg_pkg::ST_MULT:   state_in = swpg_pkg::ST_SUM1;
         swpg_pkg::ST_SUM1:   state_in = swpg_pkg::ST_SUM2;
         swpg_pkg::ST_SUM2:   state_in = swpg_pkg::ST_DONE;
         swpg_pkg::ST_DONE:   if (slot_free) state_in = swpg_pkg::ST_IDLE;
         default:             state_in = swpg_pkg::ST_IDLE;
      endcase
   end

   // shared unit operands and handshake
   always_comb begin
      alu_op    = '0;
      req_stall = (state_ff != swpg_pkg::ST_IDLE);
      case (state_ff)
         swpg_pkg::ST_CLAMP: begin
            alu_op.a   = AW'(period);
            alu_op.b   = AW'(delta_ff);
            alu_op.sub = 1'b1;
         end
         swpg_pkg::ST_ACCUM: begin
            alu_op.a = AW'(phase_ff);
            alu_op.b = AW'(delta_ff);
         end
         swpg_pkg::ST_WRAP: begin
            alu_op.a   = AW'(sum_ff);
            alu_op.b   = AW'(period);
            alu_op.sub = 1'b1;
         end
         swpg_pkg::ST_CHECK: begin
            alu_op.a   = AW'(phase_ff);
            alu_op.b   = AW'(period);
            alu_op.sub = 1'b1;
         end
         swpg_pkg::ST_DIVIDE: begin
            alu_op.a   = AW'({rem_ff, dvd_ff[W-1]});
            alu_op.b   = AW'(period);
            alu_op.sub = 1'b1;
         end
         swpg_pkg::ST_AMP: begin
            alu_op.a   = AW'($signed(cfg.max_length));
            alu_op.b   = AW'($signed(cfg.min_length));
            alu_op.sub = 1'b1;
         end
         swpg_pkg::ST_SUM1: begin
            alu_op.a = AW'($signed(cfg.min_length));
            alu_op.b = AW'(amp_ff);
         end
         swpg_pkg::ST_SUM2: begin
            alu_op.a = acc_ff;
            alu_op.b = AW'($signed(prod_ff[swpg_pkg::PROD_W-1:15]));
         end
         default: begin
            alu_op = '0;
         end
      endcase
   end

   // datapath
   always_comb begin
      delta_in        = delta_ff;
      phase_in        = phase_ff;
      sum_in          = sum_ff;
      wrapped_in      = wrapped_ff;
      rem_in          = rem_ff;
      dvd_in          = dvd_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      amp_in          = amp_ff;
      prod_in         = prod_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_position_in = rsp_position_ff;
      rsp_wrapped_in  = rsp_wrapped_ff;
      case (state_ff)
         swpg_pkg::ST_IDLE: begin
            delta_in = req_delta_t;
         end
         swpg_pkg::ST_CLAMP: begin
            if (alu_res.neg) delta_in = period;
         end
         swpg_pkg::ST_ACCUM: begin
            sum_in = alu_res.sum[W:0];
         end
         swpg_pkg::ST_WRAP: begin
            wrapped_in = !alu_res.neg;
            phase_in   = alu_res.neg ? sum_ff[W-1:0] : alu_res.sum[W-1:0];
         end
         swpg_pkg::ST_CHECK: begin
            if (alu_res.neg) begin
               rem_in = phase_ff;
               dvd_in = '0;
               cnt_in = CW'(F);
            end else begin
               rem_in = '0;
               dvd_in = phase_ff;
               cnt_in = CW'(W + F);
            end
         end
         swpg_pkg::ST_DIVIDE: begin
            rem_in = alu_res.neg ? {rem_ff[W-2:0], dvd_ff[W-1]} : alu_res.sum[W-1:0];
            quo_in = {quo_ff[F-2:0], !alu_res.neg};
            dvd_in = {dvd_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
         end
         swpg_pkg::ST_AMP: begin
            amp_in = $signed(alu_res.sum[W:1]);
         end
         swpg_pkg::ST_MULT: begin
            prod_in = amp_ff * sine;
         end
         swpg_pkg::ST_SUM1: begin
            acc_in = alu_res.sum;
         end
         swpg_pkg::ST_SUM2: begin
            acc_in = alu_res.sum;
         end
         swpg_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = acc_sat;
               rsp_wrapped_in  = wrapped_ff;
            end
         end
         default: begin
            delta_in = delta_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swpg_pkg::ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff        <= delta_in;
      sum_ff          <= sum_in;
      wrapped_ff      <= wrapped_in;
      rem_ff          <= rem_in;
      dvd_ff          <= dvd_in;
      quo_ff          <= quo_in;
      cnt_ff          <= cnt_in;
      amp_ff          <= amp_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      rsp_position_ff <= rsp_position_in;
      rsp_wrapped_ff  <= rsp_wrapped_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = $signed(rsp_position_ff);
   assign rsp_wrapped  = rsp_wrapped_ff;

endmodule

FILE: hw/rtl/sine_wave_position_generator.sv
// Top level of the sine wave position generator: register file and core.
// Depends on swpg_pkg, swpg_core and sine_wave_position_generator_assert.svh.
//
// Each request beat adds its time step (clamped to the period) to the phase and
// returns one response beat with the position min + amp + amp*sin(2*pi*phase/period).
// An item passes from acceptance to the response register through the phase-update
// states (clamp, accumulate, wrap, check), restoring division for the angle fraction,
// the scale-and-offset states (amplitude, multiply, sums) and a hand-off state; the
// division also steps through the integer bits of the phase when the period was
// lowered below the stored phase. Every datapath add, subtract and compare runs
// through one shared 36-bit unit, one step per cycle. The input is stalled while an
// item is in work; a finished response waits in its own register, so the next
// request is taken meanwhile. Write the registers only while the block is idle.
`include "sine_wave_position_generator_assert.svh"

module sine_wave_position_generator (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_delta_t,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_position,
   output logic                rsp_wrapped
);

   swpg_pkg::swpg_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            swpg_pkg::CSR_MIN_LENGTH:  cfg_in.min_length  = csr_wdata;
            swpg_pkg::CSR_MAX_LENGTH:  cfg_in.max_length  = csr_wdata;
            swpg_pkg::CSR_WAVE_PERIOD: cfg_in.wave_period = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length  <= 32'd0;
         cfg_ff.max_length  <= 32'd65536;
         cfg_ff.wave_period <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swpg_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_delta_t  (req_delta_t),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_position (rsp_position),
      .rsp_wrapped  (rsp_wrapped)
   );

   `SWPG_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && !req_stall, req_stall)
   `SWPG_ASSERT_IMP(a_result_frees_input, clock, reset, $rose(rsp_valid), !req_stall)
   `SWPG_ASSERT_IMP(a_idle_after_result, clock, reset, $fell(req_stall), rsp_valid)

endmodule
